[design/fsws_pkg.sv]
// ----------------------------------------------------------------------------
// fsws_pkg
// Shared types and constants for the frame schedule wakeup scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package fsws_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned MaxResults    = 32;
  localparam int unsigned ValW          = 16;
  localparam int unsigned CfgAddrW      = 8;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [ValW-1:0] FramesPerMajorRst = 16'd40;

  // register indexes of the config channel
  localparam logic [CfgAddrW-1:0] CfgFramesPerMajor = 8'd0;
  localparam logic [CfgAddrW-1:0] CfgEntriesInUse   = 8'd1;

  // request kinds carried on tuser
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  // one schedule table row; res tracks minor_count mod div
  typedef struct packed {
    logic [ValW-1:0] res;
    logic [ValW-1:0] off;
    logic [ValW-1:0] div;
    logic [ValW-1:0] id;
  } entry_t;

  typedef struct packed {
    logic            start;
    logic [ValW-1:0] dividend;
    logic [ValW-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

[design/fsws_mod.sv]
// ----------------------------------------------------------------------------
// fsws_mod
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsws_mod
  import fsws_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire div_req_t        req_i,
  output logic                 done_o,
  output logic [ValW-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(ValW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] dvd_q, dvd_d;
  logic [ValW-1:0] dvs_q, dvs_d;
  logic [ValW-1:0] rem_q, rem_d;
  logic [ValW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[ValW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ValW - 1);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = ValW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[ValW-1:0];
      end
      dvd_d = {dvd_q[ValW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit restarted while busy");

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished run");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(req_i.start))
    else $error("busy without a start");

endmodule

`default_nettype wire

[design/frame_schedule_wakeup_scanner_top.sv]
// ----------------------------------------------------------------------------
// frame_schedule_wakeup_scanner_top
// Minor/major frame cyclic scheduler with a loadable schedule table.
// ----------------------------------------------------------------------------
// The table lives in one synchronous RAM whose rows hold wakeup id, divisor,
// phase offset and a running residue (minor frame mod divisor). For a write
// word the residue of the current minor frame is found by a bit-serial
// remainder unit, then the row is stored. For a tick word every row passes
// through read-modify-write at one row per cycle unless the output stalls
// (the RAM read is registered), its residue advanced for the next minor
// frame; rows below entries_in_use (capped at TABLE_DEPTH and MaxResults)
// that match give results. One result is held back so that
// tlast can mark the final match; a stalled output holds the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_schedule_wakeup_scanner_top
  import fsws_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // entry_index[4:0], wakeup_id[20:5], divisor[36:21], phase_offset[52:37]
  input  wire logic [55:0]         s_axis_tdata,
  // req_type[0]
  input  wire logic                s_axis_tuser,
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // fired_id[15:0], minor_at_fire[31:16], major_at_fire[63:32]
  output logic [63:0]              m_axis_tdata,
  output logic                     m_axis_tlast
);

  localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ScanCap = (TABLE_DEPTH < MaxResults) ? TABLE_DEPTH : MaxResults;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StScan,
    StFin
  } state_e;

  state_e          state_q;
  logic [ValW-1:0] fpm_q;
  logic [5:0]      eiu_q;
  logic [ValW-1:0] minor_q;
  logic [31:0]     major_q;
  logic [AW-1:0]   idx_q;

  logic [AW-1:0]   wr_idx_q;
  logic [ValW-1:0] wr_id_q, wr_div_q, wr_off_q;

  logic            pend_valid_q;
  logic [ValW-1:0] pend_id_q;

  logic            out_valid_q;
  logic [63:0]     out_data_q;
  logic            out_last_q;

  // table RAM
  entry_t          mem_q [TABLE_DEPTH];
  entry_t          rdata_q;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  entry_t          mem_wd;

  // remainder unit
  div_req_t        div_req;
  logic            div_done;
  logic [ValW-1:0] div_rem;

  // input fields
  logic            in_acc;
  logic [4:0]      in_idx;
  logic [ValW-1:0] in_id, in_div, in_off;
  logic [6:0]      in_idx_ext;
  logic            in_idx_ok;

  // scan step
  logic [ValW:0]   minor_inc;
  logic            wrap;
  logic [ValW-1:0] minor_nx;
  logic [6:0]      scan_n;
  logic            in_scan;
  logic            fires;
  logic            out_free;
  logic            stall;
  logic            scan_go;
  logic            push;
  logic            last_row;
  logic [AW-1:0]   idx_nx;
  logic [ValW:0]   res_inc;
  logic [ValW-1:0] res_nx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[4:0];
  assign in_id         = s_axis_tdata[20:5];
  assign in_div        = s_axis_tdata[36:21];
  assign in_off        = s_axis_tdata[52:37];
  assign in_idx_ext    = 7'(in_idx);
  assign in_idx_ok     = in_idx_ext < 7'(TABLE_DEPTH);

  assign div_req.start    = in_acc && (s_axis_tuser == ReqWrite) && in_idx_ok;
  assign div_req.dividend = minor_q;
  assign div_req.divisor  = in_div;

  fsws_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  always_comb begin
    minor_inc = {1'b0, minor_q} + 17'd1;
    wrap      = minor_inc >= {1'b0, fpm_q};
    minor_nx  = wrap ? '0 : minor_inc[ValW-1:0];
    scan_n    = (7'(eiu_q) > 7'(ScanCap)) ? 7'(ScanCap) : 7'(eiu_q);
    in_scan   = 7'(idx_q) < scan_n;
    fires     = in_scan && (rdata_q.div != '0) && (rdata_q.res == rdata_q.off);
    out_free  = !out_valid_q || m_axis_tready;
    stall     = fires && pend_valid_q && !out_free;
    scan_go   = (state_q == StScan) && !stall;
    // held result moves to the output register
    push      = pend_valid_q && ((scan_go && fires) || ((state_q == StFin) && out_free));
    last_row  = idx_q == AW'(TABLE_DEPTH - 1);
    idx_nx    = last_row ? '0 : AW'(idx_q + 1'b1);
    rd_addr   = scan_go ? idx_nx : idx_q;
    // next residue for the following minor frame
    res_inc   = {1'b0, rdata_q.res} + 17'd1;
    res_nx    = (wrap || (res_inc == {1'b0, rdata_q.div})) ? '0 : res_inc[ValW-1:0];

    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = rdata_q;
    if (state_q == StDiv && div_done) begin
      mem_we     = 1'b1;
      mem_wa     = wr_idx_q;
      mem_wd.id  = wr_id_q;
      mem_wd.div = wr_div_q;
      mem_wd.off = wr_off_q;
      mem_wd.res = (wr_div_q == '0) ? '0 : div_rem;
    end else if (scan_go) begin
      mem_we     = 1'b1;
      mem_wd.res = res_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      fpm_q        <= FramesPerMajorRst;
      eiu_q        <= '0;
      minor_q      <= '0;
      major_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgFramesPerMajor: fpm_q <= cfg_data_i[ValW-1:0];
          CfgEntriesInUse:   eiu_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (in_acc) begin
            if (s_axis_tuser == ReqTick) begin
              state_q <= StScan;
            end else if (in_idx_ok) begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StIdle;
          end
        end
        StScan: begin
          if (scan_go) begin
            if (fires) begin
              if (pend_valid_q) begin
                out_data_q  <= {major_q, minor_q, pend_id_q};
                out_last_q  <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_id_q    <= rdata_q.id;
            end
            idx_q <= idx_nx;
            if (last_row) begin
              state_q <= StFin;
            end
          end
        end
        StFin: begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_data_q  <= {major_q, minor_q, pend_id_q};
              out_last_q  <= 1'b1;
            end
            pend_valid_q <= 1'b0;
            minor_q      <= minor_nx;
            if (wrap) begin
              major_q <= major_q + 32'd1;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_idx_q <= AW'(in_idx_ext);
      wr_id_q  <= in_id;
      wr_div_q <= in_div;
      wr_off_q <= in_off;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("held result left over after scan");

  a_minor_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(minor_q) |-> $past(state_q == StFin))
    else $error("minor frame moved outside scan end");

  a_we_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StScan) || (state_q == StDiv))
    else $error("table written while idle");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(out_last_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
